// ===== sv/vtm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the virtual timer multiplexer.
// No dependencies.
package vtm_pkg;

   localparam int SLOT_COUNT     = 8;
   localparam int SLOT_BITS      = $clog2(SLOT_COUNT);
   localparam int COUNTER_BITS   = 32;
   localparam int DURATION_BITS  = 32;
   localparam int PRESCALE_BITS  = 4;
   localparam int PRESCALE_MAX   = 9;
   localparam int PRESCALE_CBITS = PRESCALE_MAX;
   localparam int PRESCALE_RESET = 4;

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ONESHOT  = 2'd1;
   localparam logic [1:0] OP_REPEAT   = 2'd2;

   typedef struct packed {
      logic [1:0]               operation;
      logic [DURATION_BITS-1:0] duration;
   } req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]    assigned_slot;
      logic                    table_full;
      logic                    fired;
      logic [SLOT_BITS-1:0]    fired_slot;
      logic [COUNTER_BITS-1:0] counter_now;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ADV   = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_FIRE  = 5'b01000,
      ST_START = 5'b10000
   } state_type;

endpackage

// ===== sv/virtual_timer_multiplexer_top.sv =====
`timescale 1ns / 1ps
// Virtual timer multiplexer: slot table, prescaled counter and scan sequencer.
// Depends on vtm_pkg.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------
//   req      | req_valid / req_stall    | req_data (operation, duration)
//   rsp      | rsp_valid / rsp_stall    | rsp_data (slot, flags, counter)
//   csr      | csr_write_enable         | csr_write_data (prescale shift)
//
// A tick item steps the prescaled counter, scans the table through one subtract-and-compare
// unit behind the registered read, and then reloads or frees the winning slot. A start
// item skips the scan and goes straight to ST_START. req_stall is high from accept until
// the result is registered, and the last step waits while an earlier result is held by
// rsp_stall.
// Reset is synchronous; no clearing pass, slot state is the busy bits.
module virtual_timer_multiplexer_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  vtm_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output vtm_pkg::rsp_type            rsp_data,
   input  logic                        csr_write_enable,
   input  logic [vtm_pkg::PRESCALE_BITS-1:0] csr_write_data
);
   import vtm_pkg::*;

   state_type                   state_ff, state_in;
   logic [PRESCALE_BITS-1:0]    shift_ff;
   logic [COUNTER_BITS-1:0]     counter_ff, counter_in;
   logic [PRESCALE_CBITS-1:0]   pcount_ff, pcount_in;
   logic [SLOT_COUNT-1:0]       busy_ff, busy_in;
   logic [1:0]                  op_ff;
   logic [DURATION_BITS-1:0]    duration_ff;
   logic [SLOT_BITS:0]          scan_ff, scan_in;
   logic                        best_vld_ff, best_vld_in;
   logic [SLOT_BITS-1:0]        best_idx_ff, best_idx_in;
   logic [COUNTER_BITS-1:0]     best_lag_ff, best_lag_in;
   logic [COUNTER_BITS-1:0]     best_per_ff, best_per_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic [COUNTER_BITS-1:0]     expiry_mem [SLOT_COUNT];
   logic [COUNTER_BITS-1:0]     period_mem [SLOT_COUNT];
   logic [COUNTER_BITS-1:0]     expiry_rd_ff;
   logic [COUNTER_BITS-1:0]     period_rd_ff;
   logic [SLOT_BITS-1:0]        rd_addr;
   logic                        exp_we, per_we;
   logic [SLOT_BITS-1:0]        wr_addr;
   logic [COUNTER_BITS-1:0]     exp_wdata, per_wdata;

   logic [COUNTER_BITS-1:0]     add_b, sum;
   logic [COUNTER_BITS-1:0]     lag;
   logic [SLOT_BITS-1:0]        cmp_idx;
   logic                        take;
   logic                        out_free;
   logic                        accept;
   logic [PRESCALE_BITS-1:0]    shift_eff;
   logic [PRESCALE_CBITS:0]     limit, pcount_plus;
   logic                        free_found;
   logic [SLOT_BITS-1:0]        free_idx;
   logic                        is_start;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign is_start  = (op_ff == OP_ONESHOT) || (op_ff == OP_REPEAT);

   // prescaler limit, shift clamped to PRESCALE_MAX
   assign shift_eff   = (shift_ff > PRESCALE_BITS'(PRESCALE_MAX)) ?
                        PRESCALE_BITS'(PRESCALE_MAX) : shift_ff;
   assign limit       = (PRESCALE_CBITS+1)'(1) << shift_eff;
   assign pcount_plus = {1'b0, pcount_ff} + (PRESCALE_CBITS+1)'(1);

   // shared adder: counter step, start expiry, periodic reload
   always_comb begin
      case (state_ff)
         ST_ADV:   add_b = COUNTER_BITS'(1);
         ST_START: add_b = duration_ff[COUNTER_BITS-1:0];
         default:  add_b = best_per_ff;
      endcase
   end
   assign sum = counter_ff + add_b;

   // scan compare: slot read last cycle against the best so far
   assign rd_addr = scan_ff[SLOT_BITS-1:0];
   assign cmp_idx = rd_addr - SLOT_BITS'(1);
   assign lag     = counter_ff - expiry_rd_ff;
   assign take    = (scan_ff != '0) && busy_ff[cmp_idx] && !lag[COUNTER_BITS-1] &&
                    (!best_vld_ff || (lag > best_lag_ff));

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      pcount_in    = pcount_ff;
      busy_in      = busy_ff;
      scan_in      = scan_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_lag_in  = best_lag_ff;
      best_per_in  = best_per_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      exp_we       = 1'b0;
      per_we       = 1'b0;
      wr_addr      = best_idx_ff;
      exp_wdata    = sum;
      per_wdata    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.operation == OP_TICK) ? ST_ADV : ST_START;
            end
         end
         ST_ADV: begin
            if (pcount_plus >= limit) begin
               pcount_in  = '0;
               counter_in = sum;
            end else begin
               pcount_in  = pcount_plus[PRESCALE_CBITS-1:0];
            end
            scan_in     = '0;
            best_vld_in = 1'b0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (take) begin
               best_vld_in = 1'b1;
               best_idx_in = cmp_idx;
               best_lag_in = lag;
               best_per_in = period_rd_ff;
            end
            scan_in = scan_ff + (SLOT_BITS+1)'(1);
            if (scan_ff == (SLOT_BITS+1)'(SLOT_COUNT)) begin
               state_in = ST_FIRE;
            end
         end
         ST_FIRE: begin
            if (out_free) begin
               if (best_vld_ff) begin
                  if (best_per_ff != '0) begin
                     exp_we = 1'b1;
                  end else begin
                     busy_in[best_idx_ff] = 1'b0;
                  end
               end
               rsp_valid_in         = 1'b1;
               rsp_in.assigned_slot = '0;
               rsp_in.table_full    = 1'b0;
               rsp_in.fired         = best_vld_ff;
               rsp_in.fired_slot    = best_vld_ff ? best_idx_ff : '0;
               rsp_in.counter_now   = counter_ff;
               state_in             = ST_IDLE;
            end
         end
         ST_START: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.assigned_slot = '0;
               rsp_in.table_full    = 1'b0;
               rsp_in.fired         = 1'b0;
               rsp_in.fired_slot    = '0;
               rsp_in.counter_now   = counter_ff;
               if (is_start) begin
                  if (free_found) begin
                     busy_in[free_idx]    = 1'b1;
                     exp_we               = 1'b1;
                     per_we               = 1'b1;
                     wr_addr              = free_idx;
                     per_wdata            = (op_ff == OP_REPEAT) ?
                                            duration_ff[COUNTER_BITS-1:0] : '0;
                     rsp_in.assigned_slot = free_idx;
                  end else begin
                     rsp_in.table_full    = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_ff     <= PRESCALE_BITS'(PRESCALE_RESET);
         counter_ff   <= '0;
         pcount_ff    <= '0;
         busy_ff      <= '0;
         scan_ff      <= '0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         pcount_ff    <= pcount_in;
         busy_ff      <= busy_in;
         scan_ff      <= scan_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            shift_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_lag_ff <= best_lag_in;
      best_per_ff <= best_per_in;
      rsp_ff      <= rsp_in;
      if (accept) begin
         op_ff       <= req_data.operation;
         duration_ff <= req_data.duration;
      end
   end

   // slot tables: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (exp_we) begin
         expiry_mem[wr_addr] <= exp_wdata;
      end
      if (per_we) begin
         period_mem[wr_addr] <= per_wdata;
      end
      expiry_rd_ff <= expiry_mem[rd_addr];
      period_rd_ff <= period_mem[rd_addr];
   end

endmodule

// ===== tb/sv/tb_virtual_timer_multiplexer_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for virtual_timer_multiplexer_top: directed and random ticks and
// timer starts, each result checked against a behavioral model of the slot table.
// Depends on vtm_pkg and virtual_timer_multiplexer_top.
module tb_virtual_timer_multiplexer_top;
   import vtm_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT     = 150;
   localparam int MAX_PRINTED     = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [PRESCALE_BITS-1:0] csr_write_data = '0;

   req_type timer_items_q[$];
   rsp_type timer_reports_q[$];

   // shadow copy of the block's state
   logic [PRESCALE_BITS-1:0] shadow_shift = PRESCALE_BITS'(PRESCALE_RESET);
   logic [COUNTER_BITS-1:0]  shadow_counter = '0;
   int                       shadow_tick_count = 0;
   logic [COUNTER_BITS-1:0]  shadow_expiry [SLOT_COUNT];
   logic [COUNTER_BITS-1:0]  shadow_period [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]    shadow_busy = '0;

   int sender_idle_pct = 35;
   int receiver_idle_pct = 82;
   int mismatch_count = 0;
   int results_seen = 0;
   int hold_left = 0;
   bit hold_started = 1'b0;
   int cycle_count = 0;

   virtual_timer_multiplexer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Apply one item to the shadow table and return the result it should produce.
   function automatic rsp_type apply_timer_item(input req_type item);
      rsp_type                 result;
      int                      shift;
      int                      best;
      int                      i;
      logic [COUNTER_BITS-1:0] lag;
      logic [COUNTER_BITS-1:0] best_lag;
      result = '0;
      case (item.operation)
         OP_TICK: begin
            shift = (shadow_shift > PRESCALE_MAX) ? PRESCALE_MAX : int'(shadow_shift);
            shadow_tick_count++;
            if (shadow_tick_count >= (1 << shift)) begin
               shadow_tick_count = 0;
               shadow_counter = shadow_counter + 1'b1;
            end
            best = -1;
            best_lag = '0;
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (shadow_busy[i]) begin
                  lag = shadow_counter - shadow_expiry[i];
                  // due when the wrapped difference reads as non-negative; oldest wins
                  if (!lag[COUNTER_BITS-1] && (best < 0 || lag > best_lag)) begin
                     best = i;
                     best_lag = lag;
                  end
               end
            end
            if (best >= 0) begin
               if (shadow_period[best] != '0)
                  shadow_expiry[best] = shadow_counter + shadow_period[best];
               else
                  shadow_busy[best] = 1'b0;
               result.fired = 1'b1;
               result.fired_slot = SLOT_BITS'(best);
            end
         end
         OP_ONESHOT, OP_REPEAT: begin
            result.table_full = 1'b1;
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (!shadow_busy[i] && result.table_full) begin
                  shadow_busy[i] = 1'b1;
                  shadow_expiry[i] = shadow_counter + item.duration[COUNTER_BITS-1:0];
                  shadow_period[i] = (item.operation == OP_REPEAT) ?
                                     item.duration[COUNTER_BITS-1:0] : '0;
                  result.table_full = 1'b0;
                  result.assigned_slot = SLOT_BITS'(i);
               end
            end
         end
         default: begin
         end
      endcase
      result.counter_now = shadow_counter;
      return result;
   endfunction

   function automatic logic [DURATION_BITS-1:0] pick_duration();
      int roll;
      roll = $urandom_range(99);
      if (roll < 35)
         return $urandom_range(3);
      else if (roll < 80)
         return $urandom_range(60, 4);
      // far behind the counter: due on the next tick, and toggles the upper bits
      else
         return 32'hFFFF_FFFF - $urandom_range(32'h7FFE_FFFF);
   endfunction

   // Repeating timers with a nonzero period never free their slot, so keep them
   // out of all but the last phase.
   function automatic req_type random_timer_item(input bit with_periodic);
      req_type item;
      int      roll;
      roll = $urandom_range(99);
      item.duration = pick_duration();
      if (roll < 55)
         item.operation = OP_TICK;
      else if (roll < 80)
         item.operation = OP_ONESHOT;
      else if (roll < 92) begin
         item.operation = OP_REPEAT;
         if (!with_periodic || $urandom_range(1) == 0)
            item.duration = '0;
         else
            item.duration = $urandom_range(40, 1);
      end else
         item.operation = OP_UNUSED;
      return item;
   endfunction

   task automatic queue_item(input logic [1:0] op, input logic [DURATION_BITS-1:0] length);
      req_type item;
      item.operation = op;
      item.duration = length;
      timer_items_q.push_back(item);
   endtask

   task automatic drain_timers();
      while (timer_items_q.size() != 0 || req_valid || timer_reports_q.size() != 0)
         @(posedge clock);
      repeat (SLOT_COUNT + 8) @(posedge clock);
   endtask

   task automatic run_phase(input logic [PRESCALE_BITS-1:0] shift, input int sender_pct,
                            input int receiver_pct, input int item_count,
                            input bit with_periodic);
      drain_timers();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= shift;
      shadow_shift = shift;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
      repeat (item_count) timer_items_q.push_back(random_timer_item(with_periodic));
   endtask

   task automatic report_mismatch(input string message);
      if (mismatch_count < MAX_PRINTED)
         $display("MISMATCH at cycle %0d: %s", cycle_count, message);
      mismatch_count++;
   endtask

   // driver: hold a stalled item, otherwise offer the next pending one unless idling
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            timer_reports_q.push_back(apply_timer_item(req_data));
            void'(timer_items_q.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (timer_items_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= timer_items_q[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted result, drive stall, hold off once to back up the input
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (timer_reports_q.size() == 0) begin
               report_mismatch("result with no prediction pending");
            end else begin
               want = timer_reports_q.pop_front();
               if (rsp_data.assigned_slot !== want.assigned_slot)
                  report_mismatch($sformatf("result %0d assigned_slot %0d, predicted %0d",
                     results_seen, rsp_data.assigned_slot, want.assigned_slot));
               if (rsp_data.table_full !== want.table_full)
                  report_mismatch($sformatf("result %0d table_full %0b, predicted %0b",
                     results_seen, rsp_data.table_full, want.table_full));
               if (rsp_data.fired !== want.fired)
                  report_mismatch($sformatf("result %0d fired %0b, predicted %0b",
                     results_seen, rsp_data.fired, want.fired));
               if (rsp_data.fired_slot !== want.fired_slot)
                  report_mismatch($sformatf("result %0d fired_slot %0d, predicted %0d",
                     results_seen, rsp_data.fired_slot, want.fired_slot));
               if (rsp_data.counter_now !== want.counter_now)
                  report_mismatch($sformatf("result %0d counter_now %0h, predicted %0h",
                     results_seen, rsp_data.counter_now, want.counter_now));
            end
            results_seen++;
         end
         if (!hold_started && results_seen >= HOLD_OFF_AT) begin
            hold_started = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset prescale, wrap-aware due test, ties, full table, unused opcode
      queue_item(OP_TICK, '0);
      queue_item(OP_ONESHOT, '0);
      queue_item(OP_TICK, '0);
      queue_item(OP_UNUSED, 32'hFFFF_FFFF);
      queue_item(OP_REPEAT, '0);
      queue_item(OP_ONESHOT, 32'hFFFF_FFFF);
      queue_item(OP_ONESHOT, 32'd1);
      queue_item(OP_TICK, '0);
      queue_item(OP_TICK, '0);
      repeat (7) queue_item(OP_ONESHOT, 32'd2);
      queue_item(OP_REPEAT, 32'd5);
      queue_item(OP_ONESHOT, 32'd3);
      queue_item(OP_UNUSED, '0);
      repeat (5) queue_item(OP_TICK, '0);

      run_phase(4'd0, 35, 82, 600, 1'b0);
      run_phase(4'd15, 82, 35, 250, 1'b0);
      run_phase(4'd3, 82, 35, 250, 1'b0);
      run_phase(4'd9, 0, 0, 200, 1'b0);
      run_phase(4'd0, 0, 0, 450, 1'b1);
      drain_timers();

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/vtm_pkg.sv
sv/virtual_timer_multiplexer_top.sv
tb/sv/tb_virtual_timer_multiplexer_top.sv
